// ===== src/smig_pkg.sv =====
// Shared types, constants and helpers for the sphere mesh index generator.
// Depends on nothing; every other file in src imports it.
package smig_pkg;

    localparam int COUNT_W     = 16;
    localparam int PROD_W      = 2 * COUNT_W;
    localparam int CFG_INDEX_W = 8;

    typedef logic [COUNT_W-1:0]     count_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Register indexes of the configuration channel
    localparam cfg_index_t CFG_AROUND = 8'd0;
    localparam cfg_index_t CFG_DOWN   = 8'd1;

    localparam count_t MIN_SEGMENTS   = 16'd2;
    localparam count_t RESET_SEGMENTS = 16'd16;
    localparam logic [PROD_W-1:0] PRODUCT_LIMIT = 32'd32767;

    // Effective mesh shape: counts, top pole index and base of the last ring
    typedef struct packed {
        count_t around;
        count_t down;
        count_t top;
        count_t low;
    } shape_t;

    // Shape for the reset configuration (16 x 16)
    localparam shape_t RESET_SHAPE = '{around: 16'd16, down: 16'd16,
                                       top: 16'd272, low: 16'd255};
    // Shape held before the first restart (2 x 2)
    localparam shape_t IDLE_SHAPE  = '{around: 16'd2, down: 16'd2,
                                       top: 16'd6, low: 16'd3};

    typedef struct packed {
        count_t first;
        count_t second;
        count_t third;
        logic   last;
        logic   exhausted;
    } tri_t;

    typedef enum logic [1:0] {
        SEC_RINGS = 2'b01,
        SEC_CAPS  = 2'b10
    } section_t;

    function automatic count_t clamp_count(input count_t value);
        clamp_count = (value < MIN_SEGMENTS) ? MIN_SEGMENTS : value;
    endfunction

endpackage

// ===== src/sphere_mesh_index_generator_core.sv =====
// Top level of the sphere mesh index generator.
// Depends on smig_pkg, smig_shape, smig_walk and smig_skid.
//
// Streams the triangle index list of a latitude-longitude sphere, one
// triangle for each input transfer. A transfer with restart set latches the
// effective segment counts and yields the first triangle; later transfers
// yield the following ones: per ring the quad pairs ending with the wrap
// pair, then the top and bottom cap pairs, 2*X*Y triangles in all, the last
// one marked by m_tlast. Transfers past the end return zero indices with the
// exhausted flag set. Throughput is one triangle per clock while s_tready
// is high: the walker's counter update and index adds sit between the
// input handshake and a two-entry output buffer, so input is taken while
// a result waits. Writing either configuration register starts the count
// reduction (clamp to 2, then one multiply-compare-halve per cycle), which
// holds s_tready low; the new counts apply at the next restart.
module sphere_mesh_index_generator_core #(
    parameter int INDEX_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  smig_pkg::cfg_index_t          cfg_index,
    input  smig_pkg::count_t              cfg_data,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] restart
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [((3*INDEX_BITS+7)/8)*8-1:0] m_tdata, // first, second, third index
    output logic                          m_tlast,   // last_triangle
    output logic [0:0]                    m_tuser    // [0] exhausted
);
    import smig_pkg::*;

    shape_t shape;
    tri_t   triangle;
    tri_t   out_tri;
    logic   shape_busy;
    logic   buf_ready;
    logic   step;

    // hold input while the count reduction runs or the buffer is full
    assign s_tready = buf_ready && !shape_busy;
    assign step     = s_tvalid && s_tready;

    smig_shape u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (shape_busy),
        .shape     (shape)
    );

    smig_walk u_walk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .restart  (s_tdata[0]),
        .shape    (shape),
        .triangle (triangle)
    );

    smig_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (step),
        .in_ready  (buf_ready),
        .in_data   (triangle),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_tri)
    );

    // pack indices from the lowest bits up; zero-fill to whole bytes
    always_comb begin
        m_tdata = '0;
        m_tdata[INDEX_BITS-1:0]              = INDEX_BITS'(out_tri.first);
        m_tdata[2*INDEX_BITS-1:INDEX_BITS]   = INDEX_BITS'(out_tri.second);
        m_tdata[3*INDEX_BITS-1:2*INDEX_BITS] = INDEX_BITS'(out_tri.third);
    end

    assign m_tlast    = out_tri.last;
    assign m_tuser[0] = out_tri.exhausted;

endmodule

// ===== src/smig_shape.sv =====
// Configuration registers and effective segment count reduction.
// Depends on smig_pkg.
module smig_shape (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  smig_pkg::cfg_index_t  cfg_index,
    input  smig_pkg::count_t      cfg_data,
    output logic                  busy,
    output smig_pkg::shape_t      shape
);
    import smig_pkg::*;

    count_t            around_reg;
    count_t            down_reg;
    count_t            x_reg;
    count_t            y_reg;
    logic              busy_reg;
    shape_t            shape_reg;
    logic [PROD_W-1:0] prod;
    logic              over;
    count_t            top_calc;
    count_t            low_calc;

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;
    assign shape     = shape_reg;

    // one multiply and compare per cycle; halve both counts while too large
    assign prod     = PROD_W'(x_reg) * PROD_W'(y_reg);
    assign over     = prod > PRODUCT_LIMIT;
    assign top_calc = prod[COUNT_W-1:0] + y_reg;
    assign low_calc = top_calc - x_reg - 16'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            around_reg <= RESET_SEGMENTS;
            down_reg   <= RESET_SEGMENTS;
            busy_reg   <= 1'b0;
            shape_reg  <= RESET_SHAPE;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_AROUND: begin
                    around_reg <= cfg_data;
                    x_reg      <= clamp_count(cfg_data);
                    y_reg      <= clamp_count(down_reg);
                    busy_reg   <= 1'b1;
                end
                CFG_DOWN: begin
                    down_reg <= cfg_data;
                    x_reg    <= clamp_count(around_reg);
                    y_reg    <= clamp_count(cfg_data);
                    busy_reg <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (busy_reg) begin
            if (over) begin
                x_reg <= x_reg >> 1;
                y_reg <= y_reg >> 1;
            end else begin
                shape_reg <= '{around: x_reg, down: y_reg, top: top_calc, low: low_calc};
                busy_reg  <= 1'b0;
            end
        end
    end

endmodule

// ===== src/smig_walk.sv =====
// Triangle walker: run counters and the index arithmetic of one triangle.
// Depends on smig_pkg.
module smig_walk (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              restart,
    input  smig_pkg::shape_t  shape,
    output smig_pkg::tri_t    triangle
);
    import smig_pkg::*;

    shape_t   eff_reg,  eff_cur;
    count_t   seg_reg,  seg_cur,  seg_next;
    count_t   ring_reg, ring_cur, ring_next;
    count_t   base_reg, base_cur, base_next;
    section_t sec_reg,  sec_cur,  sec_next;
    logic     half_reg, half_cur, half_next;
    logic     fin_reg,  fin_cur,  fin_next;

    count_t          pitch;
    count_t          cur;
    logic [COUNT_W:0] seg_inc;
    logic [COUNT_W:0] ring_inc2;
    logic            wrap;
    tri_t            tri_c;

    // restart applies the pending shape and zeroed counters to this item
    always_comb begin
        if (restart) begin
            eff_cur  = shape;
            seg_cur  = '0;
            ring_cur = '0;
            base_cur = '0;
            half_cur = 1'b0;
            fin_cur  = 1'b0;
            sec_cur  = (shape.down > 16'd1) ? SEC_RINGS : SEC_CAPS;
        end else begin
            eff_cur  = eff_reg;
            seg_cur  = seg_reg;
            ring_cur = ring_reg;
            base_cur = base_reg;
            half_cur = half_reg;
            fin_cur  = fin_reg;
            sec_cur  = sec_reg;
        end
    end

    assign pitch     = eff_cur.around + 16'd1;
    assign cur       = base_cur + seg_cur;
    assign seg_inc   = {1'b0, seg_cur} + 17'd1;
    assign ring_inc2 = {1'b0, ring_cur} + 17'd2;
    assign wrap      = seg_inc >= {1'b0, eff_cur.around};

    always_comb begin
        tri_c = '0;
        if (fin_cur) begin
            tri_c.exhausted = 1'b1;
        end else begin
            unique case (sec_cur)
                SEC_RINGS: begin
                    tri_c.first = cur + pitch;
                    if (!half_cur) begin
                        tri_c.second = cur;
                        tri_c.third  = cur + 16'd1;
                    end else begin
                        tri_c.second = cur + 16'd1;
                        tri_c.third  = cur + 16'd1 + pitch;
                    end
                end
                SEC_CAPS: begin
                    if (!half_cur) begin
                        tri_c.first  = eff_cur.top;
                        tri_c.second = seg_inc[COUNT_W-1:0];
                        tri_c.third  = seg_cur;
                    end else begin
                        tri_c.first  = eff_cur.low + seg_cur;
                        tri_c.second = wrap ? eff_cur.low
                                            : eff_cur.low + seg_inc[COUNT_W-1:0];
                        tri_c.third  = eff_cur.top + 16'd1;
                        tri_c.last   = wrap;
                    end
                end
                default: tri_c.exhausted = 1'b1;
            endcase
        end
    end

    assign triangle = tri_c;

    // advance after the second triangle of each pair
    always_comb begin
        seg_next  = seg_cur;
        ring_next = ring_cur;
        base_next = base_cur;
        sec_next  = sec_cur;
        half_next = half_cur;
        fin_next  = fin_cur;
        if (!tri_c.exhausted) begin
            half_next = !half_cur;
            if (half_cur) begin
                if (wrap) begin
                    seg_next = '0;
                    if (sec_cur == SEC_RINGS) begin
                        ring_next = seg_inc[COUNT_W-1:0] - seg_cur + ring_cur;
                        base_next = base_cur + pitch;
                        if (ring_inc2 >= {1'b0, eff_cur.down}) begin
                            sec_next = SEC_CAPS;
                        end
                    end else begin
                        fin_next = 1'b1;
                    end
                end else begin
                    seg_next = seg_inc[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_reg  <= IDLE_SHAPE;
            seg_reg  <= '0;
            ring_reg <= '0;
            base_reg <= '0;
            sec_reg  <= SEC_RINGS;
            half_reg <= 1'b0;
            fin_reg  <= 1'b1;
        end else if (step) begin
            eff_reg  <= eff_cur;
            seg_reg  <= seg_next;
            ring_reg <= ring_next;
            base_reg <= base_next;
            sec_reg  <= sec_next;
            half_reg <= half_next;
            fin_reg  <= fin_next;
        end
    end

endmodule

// ===== src/smig_skid.sv =====
// Two-entry output buffer (result register plus skid register) for triangles.
// Depends on smig_pkg.
module smig_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  smig_pkg::tri_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output smig_pkg::tri_t  out_data
);
    import smig_pkg::*;

    tri_t out_reg;
    tri_t skid_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic take;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign take      = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (out_valid_reg && !out_ready) begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end else begin
                out_reg       <= in_data;
                out_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== dv/tb_sphere_mesh_index_generator_core.sv =====
// Self-checking testbench for sphere_mesh_index_generator_core.
// Depends on smig_pkg and the core RTL. It predicts every triangle in place and
// checks the result stream under random stalls on both sides.
`timescale 1ns / 100ps

module tb_sphere_mesh_index_generator_core;
    import smig_pkg::*;

    localparam int INDEX_BITS  = 16;
    localparam int DATA_W      = ((3 * INDEX_BITS + 7) / 8) * 8;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int unsigned AREA_LIMIT = 32767;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    cfg_index_t        cfg_index = CFG_AROUND;
    count_t            cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic [0:0]        m_tuser;

    sphere_mesh_index_generator_core #(.INDEX_BITS(INDEX_BITS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mesh walker shadow: configuration as written, shape latched at restart
    // and the position of the next triangle in the emission order.
    // ------------------------------------------------------------------
    count_t   req_around = RESET_SEGMENTS;
    count_t   req_down   = RESET_SEGMENTS;
    count_t   mesh_x     = 16'd2;
    count_t   mesh_y     = 16'd2;
    count_t   ring_num   = '0;
    count_t   seg_num    = '0;
    count_t   ring_start = '0;
    section_t phase      = SEC_RINGS;
    bit       upper_half = 1'b0;     // second triangle of the current pair
    bit       sphere_done = 1'b1;    // nothing to emit until the first restart

    tri_t pending_tris[$];

    int errors         = 0;
    int items_sent     = 0;
    int restarts       = 0;
    int spheres_closed = 0;
    int exhausted_seen = 0;
    int reg_writes     = 0;
    int cycles         = 0;

    // sender pacing
    int burst_left  = 0;
    bit burst_calm  = 1'b0;
    // receiver pacing; hold_request is picked up by the receiver process
    int hold_request = 0;
    int hold_left    = 0;
    int stall_mode   = 0;
    int mode_left    = 0;
    int stall_phase  = 0;

    // Work out the triangle for one tick and advance the walk.
    function automatic tri_t next_triangle(input bit restart);
        tri_t        tri_out;
        int unsigned x, y, p, s, cur, top, low;
        tri_out = '0;
        if (restart) begin
            x = (req_around < 2) ? 2 : req_around;
            y = (req_down < 2) ? 2 : req_down;
            while (x * y > AREA_LIMIT) begin
                x = x >> 1;
                y = y >> 1;
            end
            mesh_x      = count_t'(x);
            mesh_y      = count_t'(y);
            ring_num    = '0;
            seg_num     = '0;
            ring_start  = '0;
            upper_half  = 1'b0;
            phase       = (y > 1) ? SEC_RINGS : SEC_CAPS;
            sphere_done = 1'b0;
        end
        if (sphere_done) begin
            tri_out.exhausted = 1'b1;
            return tri_out;
        end
        x = mesh_x;
        y = mesh_y;
        p = x + 1;
        s = seg_num;
        if (phase == SEC_RINGS) begin
            cur           = ring_start + s;
            tri_out.first = count_t'(cur + p);
            if (!upper_half) begin
                tri_out.second = count_t'(cur);
                tri_out.third  = count_t'(cur + 1);
            end else begin
                tri_out.second = count_t'(cur + 1);
                tri_out.third  = count_t'(cur + 1 + p);
            end
        end else begin
            top = p * y;
            low = (y - 1) * p;
            if (!upper_half) begin
                tri_out.first  = count_t'(top);
                tri_out.second = count_t'(s + 1);
                tri_out.third  = count_t'(s);
            end else begin
                // the final bottom triangle wraps back to the start of the ring
                tri_out.first  = count_t'(low + s);
                tri_out.second = count_t'((s + 1 >= x) ? low : low + s + 1);
                tri_out.third  = count_t'(top + 1);
                tri_out.last   = (s + 1 >= x);
            end
        end
        if (!upper_half) begin
            upper_half = 1'b1;
        end else begin
            upper_half = 1'b0;
            seg_num    = seg_num + 1'b1;
            if (seg_num >= mesh_x) begin
                seg_num = '0;
                if (phase == SEC_RINGS) begin
                    ring_num   = ring_num + 1'b1;
                    ring_start = ring_start + count_t'(p);
                    if (ring_num + 1 >= y) phase = SEC_CAPS;
                end else begin
                    sphere_done = 1'b1;
                end
            end
        end
        return tri_out;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one tick transfer, in bursts with random gaps in between.
    // s_tvalid stays high after a transfer until the next call or a stop.
    // ------------------------------------------------------------------
    task automatic send_tick(input bit restart);
        int   gap;
        tri_t tri_item;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            burst_calm = ($urandom_range(0, 3) == 0);
            gap        = burst_calm ? 0 : $urandom_range(0, 6);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tri_item = next_triangle(restart);
        pending_tris.push_back(tri_item);
        items_sent++;
        if (restart) restarts++;
        if (tri_item.last) spheres_closed++;
    endtask

    // Drop valid and wait until every expected triangle is back.
    task automatic drain;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_tris.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write; only called with the block idle.
    task automatic write_reg(input cfg_index_t idx, input count_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_AROUND) req_around = value;
        else req_down = value;
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: long holds on request, otherwise a stall pattern that
    // switches between always ready, sparse, heavy and periodic stalls.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        stall_phase = (stall_phase + 1) % 7;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= $urandom_range(0, 1);
                default: m_tready <= (stall_phase > 2);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result against the oldest expectation.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d actual %0d",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        tri_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tris.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none actual %h/%b/%b",
                         $time, m_tdata, m_tlast, m_tuser);
            end else begin
                want = pending_tris.pop_front();
                check_field("first_index", want.first, m_tdata[15:0]);
                check_field("second_index", want.second, m_tdata[31:16]);
                check_field("third_index", want.third, m_tdata[47:32]);
                check_field("last_triangle", want.last, m_tlast);
                check_field("exhausted", want.exhausted, m_tuser[0]);
                if (m_tuser[0]) exhausted_seen++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_tris.size());
            $display("[sphere_mesh_index_generator_core] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks before any restart report exhausted.
    task automatic test_before_restart;
        repeat (3) send_tick(1'b0);
    endtask

    // Counts of 0 and 1 clamp to a 2 x 2 sphere; run past its end.
    task automatic test_minimum_clamp;
        drain;
        write_reg(CFG_AROUND, 16'd0);
        write_reg(CFG_DOWN, 16'd1);
        send_tick(1'b1);
        repeat (9) send_tick(1'b0);
    endtask

    // Large requests halve down, including to a single ring or a single segment.
    task automatic test_halving_extremes;
        drain;
        write_reg(CFG_AROUND, 16'hFFFF);
        write_reg(CFG_DOWN, 16'hFFFF);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain;
        write_reg(CFG_DOWN, 16'd2);          // one ring: caps only
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain;
        write_reg(CFG_AROUND, 16'd3);
        write_reg(CFG_DOWN, 16'hFFFF);       // one segment: wrap pairs only
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
    endtask

    // A write in the middle of a sphere leaves the running shape alone.
    task automatic test_config_mid_run;
        drain;
        write_reg(CFG_AROUND, 16'd3);
        write_reg(CFG_DOWN, 16'd2);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        drain;
        write_reg(CFG_AROUND, 16'd7);
        repeat (8) send_tick(1'b0);
    endtask

    // Hold the receiver off long enough to fill the output buffer and stall
    // the input, then release it.
    task automatic test_backpressure;
        drain;
        write_reg(CFG_AROUND, 16'd5);
        write_reg(CFG_DOWN, 16'd4);
        hold_request = 300;
        send_tick(1'b1);
        repeat (41) send_tick(1'b0);
        drain;
    endtask

    // Mostly complete spheres of random shape, some cut short by a restart,
    // some huge shapes run partially, plus noise with random restart bits.
    task automatic test_random_spheres;
        int unsigned pick, total, n, k;
        bit          mid_write;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(5, 15)) send_tick($urandom_range(0, 9) == 0);
            end else begin
                if ($urandom_range(0, 3) != 0) begin
                    drain;
                    if (pick < 80) begin
                        write_reg(CFG_AROUND, count_t'($urandom_range(0, 12)));
                        write_reg(CFG_DOWN, count_t'($urandom_range(0, 12)));
                    end else if (pick < 90) begin
                        write_reg(CFG_AROUND, count_t'($urandom_range(0, 40)));
                        write_reg(CFG_DOWN, count_t'($urandom_range(0, 40)));
                    end else if (pick < 95) begin
                        write_reg(CFG_AROUND, count_t'($urandom_range(0, 65535)));
                        write_reg(CFG_DOWN, count_t'($urandom_range(0, 65535)));
                    end else begin
                        // change one register only
                        write_reg($urandom_range(0, 1) ? CFG_DOWN : CFG_AROUND,
                                  count_t'($urandom_range(0, 10)));
                    end
                end
                send_tick(1'b1);
                total = 2 * mesh_x * mesh_y;
                if (total > 400) n = $urandom_range(20, 60);
                else if ($urandom_range(0, 6) == 0) n = $urandom_range(0, total - 1);
                else n = total - 1 + $urandom_range(0, 2);
                mid_write = ($urandom_range(0, 9) == 0) && (n > 4);
                for (k = 0; k < n; k++) begin
                    if (mid_write && k == n / 2) begin
                        drain;
                        write_reg(CFG_DOWN, count_t'($urandom_range(0, 12)));
                    end
                    send_tick(1'b0);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_before_restart;
        test_minimum_clamp;
        test_halving_extremes;
        test_config_mid_run;
        test_backpressure;
        test_random_spheres;

        drain;
        repeat (10) @(posedge aclk);
        $display("covered %0d ticks, %0d restarts, %0d complete spheres",
                 items_sent, restarts, spheres_closed);
        $display("%0d exhausted replies, %0d register writes, %0d cycles",
                 exhausted_seen, reg_writes, cycles);
        if (errors == 0) begin
            $display("[sphere_mesh_index_generator_core] OK");
        end else begin
            $display("[sphere_mesh_index_generator_core] ERROR");
        end
        $finish;
    end

endmodule
